/* src/lfb_pkg.sv */
// shared types and constants for the led fade and blink controller
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lfb_pkg;

    localparam int TIME_BITS     = 32;
    localparam int ACC_BITS      = 5;
    localparam int LEVEL_BITS    = 8;
    localparam int SPAN_BITS     = 16;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;
    localparam int DIV_CNT_BITS  = $clog2(TIME_BITS);

    localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = '1;

    // phase codes
    localparam logic [1:0] PH_OFF     = 2'd0;
    localparam logic [1:0] PH_RISING  = 2'd1;
    localparam logic [1:0] PH_ON      = 2'd2;
    localparam logic [1:0] PH_FALLING = 2'd3;

    // action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ON    = 2'd1;
    localparam logic [1:0] ACT_OFF   = 2'd2;
    localparam logic [1:0] ACT_BLINK = 2'd3;

    // register indexes
    localparam logic [2:0] REG_MAX_LEVEL = 3'd0;
    localparam logic [2:0] REG_RISE_MS   = 3'd1;
    localparam logic [2:0] REG_FALL_MS   = 3'd2;
    localparam logic [2:0] REG_ON_MS     = 3'd3;
    localparam logic [2:0] REG_PERIOD_MS = 3'd4;
    localparam logic [2:0] REG_INVERTED  = 3'd5;

    typedef struct packed {
        logic [1:0]           action;
        logic [TIME_BITS-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  soft_bit;
        logic [1:0]            phase_out;
        logic                  blinking;
    } t_out_word;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] max_level;
        logic [SPAN_BITS-1:0]  rise_ms;
        logic [SPAN_BITS-1:0]  fall_ms;
        logic [SPAN_BITS-1:0]  on_ms;
        logic [SPAN_BITS-1:0]  period_ms;
        logic                  inverted;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic start;
        logic apply;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_ctrl_status;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_APPLY = 4'b1000
    } t_state;

endpackage

`default_nettype wire

/* src/lfb_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on lfb_pkg; a zero divisor yields a zero quotient
`timescale 1ns / 1ps
`default_nettype none

module lfb_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [lfb_pkg::TIME_BITS-1:0] i_num,
    input  wire logic [lfb_pkg::SPAN_BITS-1:0] i_den,
    output logic                               o_busy,
    output logic [lfb_pkg::TIME_BITS-1:0]      o_quot
);
    import lfb_pkg::*;

    logic                    r_busy, n_busy;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [TIME_BITS-1:0]    r_quot, n_quot;
    logic [SPAN_BITS-1:0]    r_rem, n_rem;
    logic [SPAN_BITS-1:0]    r_den, n_den;
    logic [SPAN_BITS:0]      w_shift;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_den   = r_den;
        w_shift = {r_rem, r_quot[TIME_BITS-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem  = SPAN_BITS'(w_shift - {1'b0, r_den});
                n_quot = {r_quot[TIME_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_shift[SPAN_BITS-1:0];
                n_quot = {r_quot[TIME_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_BITS'(TIME_BITS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_busy = r_busy;
    assign o_quot = (r_den == '0) ? '0 : r_quot;

endmodule

`default_nettype wire

/* src/lfb_datapath.sv */
// datapath: phase state, timing, ramp operands, multiplier, divider and output register
// depends on lfb_pkg and lfb_div; driven by lfb_ctrl through command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lfb_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lfb_pkg::t_cfg         i_cfg,
    input  wire lfb_pkg::t_in_word     i_in_word,
    input  wire lfb_pkg::t_ctrl_cmd    i_cmd,
    output lfb_pkg::t_ctrl_status      o_status,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output lfb_pkg::t_out_word         o_out_word
);
    import lfb_pkg::*;

    t_in_word              r_item;
    logic [1:0]            r_phase, n_phase;
    logic [TIME_BITS-1:0]  r_event, n_event;
    logic [LEVEL_BITS-1:0] r_level, n_level;
    logic                  r_blink, n_blink;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic                  r_soft, n_soft;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic [SPAN_BITS-1:0]           w_mul_a;
    logic [TIME_BITS-1:0]           w_mul_b;
    logic [SPAN_BITS-1:0]           w_den;
    logic [SPAN_BITS+TIME_BITS-1:0] w_prod;
    logic [TIME_BITS-1:0]           w_ramp_span;
    logic [TIME_BITS-1:0]           w_now;
    logic [TIME_BITS-1:0]           w_quot;
    logic                           w_div_busy;
    logic                           w_before;
    logic                           w_due;
    logic [LEVEL_BITS-1:0]          w_v;
    logic [ACC_BITS:0]              w_acc_sum;
    logic [SPAN_BITS+1:0]           w_blink_need;

    assign w_now = r_item.now_ms;

    // multiplier and divisor operands
    always_comb begin
        w_ramp_span = (r_phase == PH_RISING) ? TIME_BITS'(i_cfg.rise_ms)
                                             : TIME_BITS'(i_cfg.fall_ms);
        case (r_item.action)
            ACT_TICK: begin
                w_mul_a = SPAN_BITS'(i_cfg.max_level);
                w_mul_b = w_now - (r_event - w_ramp_span);
                w_den   = w_ramp_span[SPAN_BITS-1:0];
            end
            ACT_ON: begin
                w_mul_a = i_cfg.rise_ms;
                w_mul_b = r_event - w_now;
                w_den   = i_cfg.fall_ms;
            end
            ACT_OFF: begin
                w_mul_a = i_cfg.fall_ms;
                w_mul_b = r_event - w_now;
                w_den   = i_cfg.rise_ms;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
                w_den   = '0;
            end
        endcase
        w_prod = (SPAN_BITS+TIME_BITS)'(w_mul_a) * (SPAN_BITS+TIME_BITS)'(w_mul_b);
    end

    lfb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num   (w_prod[TIME_BITS-1:0]),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    // state update
    always_comb begin
        n_phase  = r_phase;
        n_event  = r_event;
        n_level  = r_level;
        n_blink  = r_blink;
        n_acc    = r_acc;
        n_soft   = r_soft;
        w_before = (w_now < r_event);
        w_due    = !w_before;
        w_v      = w_quot[LEVEL_BITS-1:0];
        w_acc_sum    = '0;
        w_blink_need = (SPAN_BITS+2)'(i_cfg.rise_ms) + (SPAN_BITS+2)'(i_cfg.on_ms)
                     + (SPAN_BITS+2)'(i_cfg.fall_ms);
        case (r_item.action)
            ACT_TICK: begin
                case (r_phase)
                    PH_OFF: begin
                        if (r_blink && w_due) begin
                            n_event = w_now + TIME_BITS'(i_cfg.rise_ms);
                            n_phase = PH_RISING;
                        end
                    end
                    PH_RISING: begin
                        if (w_before) begin
                            n_level = i_cfg.inverted ? LEVEL_FULL - w_v : w_v;
                        end else begin
                            n_level = i_cfg.inverted ? LEVEL_FULL - i_cfg.max_level
                                                     : i_cfg.max_level;
                            n_event = w_now + TIME_BITS'(i_cfg.on_ms);
                            n_phase = PH_ON;
                        end
                    end
                    PH_ON: begin
                        if (r_blink && w_due) begin
                            n_event = w_now + TIME_BITS'(i_cfg.fall_ms);
                            n_phase = PH_FALLING;
                        end
                    end
                    default: begin
                        if (w_before) begin
                            n_level = i_cfg.inverted ? w_v + ~i_cfg.max_level
                                                     : i_cfg.max_level - w_v;
                        end else begin
                            n_level = i_cfg.inverted ? LEVEL_FULL : '0;
                            n_phase = PH_OFF;
                            n_event = w_now + TIME_BITS'(i_cfg.period_ms)
                                    - TIME_BITS'(i_cfg.on_ms) - TIME_BITS'(i_cfg.rise_ms)
                                    - TIME_BITS'(i_cfg.fall_ms);
                        end
                    end
                endcase
                w_acc_sum = {1'b0, r_acc} + (ACC_BITS+1)'(i_cfg.inverted)
                          + (ACC_BITS+1)'(n_level[LEVEL_BITS-1:LEVEL_BITS-ACC_BITS]);
                n_acc  = w_acc_sum[ACC_BITS-1:0];
                n_soft = w_acc_sum[ACC_BITS];
            end
            ACT_ON: begin
                if (r_phase == PH_OFF) begin
                    n_event = w_now + TIME_BITS'(i_cfg.rise_ms);
                    n_phase = PH_RISING;
                end else if (r_phase == PH_FALLING) begin
                    n_event = w_now + w_quot;
                    n_phase = PH_RISING;
                end
                n_blink = 1'b0;
            end
            ACT_OFF: begin
                if (r_phase == PH_ON) begin
                    n_event = w_now + TIME_BITS'(i_cfg.fall_ms);
                    n_phase = PH_FALLING;
                end else if (r_phase == PH_RISING) begin
                    n_event = w_now + w_quot;
                    n_phase = PH_FALLING;
                end
                n_blink = 1'b0;
            end
            default: begin
                if ((SPAN_BITS+2)'(i_cfg.period_ms) >= w_blink_need) begin
                    n_blink = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OFF;
            r_event     <= '0;
            r_level     <= '0;
            r_blink     <= 1'b0;
            r_acc       <= '0;
            r_soft      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_phase     <= n_phase;
                r_event     <= n_event;
                r_level     <= n_level;
                r_blink     <= n_blink;
                r_acc       <= n_acc;
                r_soft      <= n_soft;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.capture) begin
            r_item <= i_in_word;
        end
        if (i_cmd.apply) begin
            r_out_word.level     <= n_level;
            r_out_word.soft_bit  <= n_soft;
            r_out_word.phase_out <= n_phase;
            r_out_word.blinking  <= n_blink;
        end
    end

    assign o_status.div_busy = w_div_busy;
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

endmodule

`default_nettype wire

/* src/lfb_ctrl.sv */
// controller state machine: accept, operand load, divide, update
// depends on lfb_pkg; commands lfb_datapath through t_ctrl_cmd
`timescale 1ns / 1ps
`default_nettype none

module lfb_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire lfb_pkg::t_ctrl_status i_status,
    output lfb_pkg::t_ctrl_cmd         o_cmd
);
    import lfb_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.apply   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (i_status.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

/* src/led_fade_blink_controller.sv */
// top level of the led fade and blink controller: register port, controller and datapath
// depends on lfb_pkg, lfb_ctrl, lfb_datapath and lfb_div
`timescale 1ns / 1ps
`default_nettype none

// One LED dimmer with off, rising, on and falling phases, switch on/off, blink mode
// and a soft PWM carry bit. Each input word gives an action and a millisecond time
// and yields exactly one output word. The result is loaded into the output register
// after these steps: capture the item, form the 16x32 product and start the divider,
// run the bit-serial divider that produces the ramp level or the rescaled deadline,
// see the divider finish, and update the state.
// Input stall is high for that whole time, and longer while the update waits on a
// stalled output, so no new item is taken before the last one is done; a finished
// word may wait in the output register while the next item is taken. Registers are
// written over the APB-style port at byte address 4*index and must only be changed
// while no item is in work.
module led_fade_blink_controller (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire lfb_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output lfb_pkg::t_out_word                     o_out_word,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lfb_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [lfb_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [lfb_pkg::CFG_DATA_BITS-1:0]      prdata,
    output logic                                   pready
);
    import lfb_pkg::*;

    t_cfg         r_cfg;
    t_ctrl_cmd    w_cmd;
    t_ctrl_status w_status;
    logic         w_cfg_wr;
    logic [2:0]   w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[CFG_ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_level <= LEVEL_BITS'(255);
            r_cfg.rise_ms   <= SPAN_BITS'(250);
            r_cfg.fall_ms   <= SPAN_BITS'(250);
            r_cfg.on_ms     <= SPAN_BITS'(200);
            r_cfg.period_ms <= SPAN_BITS'(900);
            r_cfg.inverted  <= 1'b0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_MAX_LEVEL: r_cfg.max_level <= pwdata[LEVEL_BITS-1:0];
                REG_RISE_MS:   r_cfg.rise_ms   <= pwdata[SPAN_BITS-1:0];
                REG_FALL_MS:   r_cfg.fall_ms   <= pwdata[SPAN_BITS-1:0];
                REG_ON_MS:     r_cfg.on_ms     <= pwdata[SPAN_BITS-1:0];
                REG_PERIOD_MS: r_cfg.period_ms <= pwdata[SPAN_BITS-1:0];
                REG_INVERTED:  r_cfg.inverted  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_MAX_LEVEL: prdata = CFG_DATA_BITS'(r_cfg.max_level);
            REG_RISE_MS:   prdata = CFG_DATA_BITS'(r_cfg.rise_ms);
            REG_FALL_MS:   prdata = CFG_DATA_BITS'(r_cfg.fall_ms);
            REG_ON_MS:     prdata = CFG_DATA_BITS'(r_cfg.on_ms);
            REG_PERIOD_MS: prdata = CFG_DATA_BITS'(r_cfg.period_ms);
            REG_INVERTED:  prdata = CFG_DATA_BITS'(r_cfg.inverted);
            default:       prdata = '0;
        endcase
    end

    lfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lfb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // an accepted word closes the input until its result is loaded into the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // a new result only follows work on an item
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    // divider runs only while an item is in work
    a_div_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_busy |-> o_in_stall)
        else $error("divider busy while input open");

    // the state update never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply |-> (!o_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

/* verif/tb_led_fade_blink_controller.sv */
// self-checking testbench for led_fade_blink_controller: directed and random action words
// with a cycle-free dimmer predictor in a scoreboard class, checked word by word
// depends on lfb_pkg and the led_fade_blink_controller rtl
`timescale 1ns / 1ps

import lfb_pkg::*;

class dimmer_scoreboard;
    t_cfg                  cfg;
    logic [1:0]            phase;
    logic [31:0]           event_ms;
    logic [7:0]            level;
    logic                  blink_on;
    logic [ACC_BITS-1:0]   duty_acc;
    logic                  soft_hold;
    t_out_word             pending_words[$];
    int                    errors;
    int                    n_checked;
    int                    n_reversals;
    int                    n_blink_rises;

    function new();
        cfg.max_level = 8'd255;
        cfg.rise_ms   = 16'd250;
        cfg.fall_ms   = 16'd250;
        cfg.on_ms     = 16'd200;
        cfg.period_ms = 16'd900;
        cfg.inverted  = 1'b0;
        phase         = PH_OFF;
        event_ms      = '0;
        level         = '0;
        blink_on      = 1'b0;
        duty_acc      = '0;
        soft_hold     = 1'b0;
        errors        = 0;
        n_checked     = 0;
        n_reversals   = 0;
        n_blink_rises = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_MAX_LEVEL: cfg.max_level = val[7:0];
            REG_RISE_MS:   cfg.rise_ms   = val[15:0];
            REG_FALL_MS:   cfg.fall_ms   = val[15:0];
            REG_ON_MS:     cfg.on_ms     = val[15:0];
            REG_PERIOD_MS: cfg.period_ms = val[15:0];
            REG_INVERTED:  cfg.inverted  = val[0];
            default: ;
        endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            REG_MAX_LEVEL: return {24'd0, cfg.max_level};
            REG_RISE_MS:   return {16'd0, cfg.rise_ms};
            REG_FALL_MS:   return {16'd0, cfg.fall_ms};
            REG_ON_MS:     return {16'd0, cfg.on_ms};
            REG_PERIOD_MS: return {16'd0, cfg.period_ms};
            REG_INVERTED:  return {31'd0, cfg.inverted};
            default:       return '0;
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // linear ramp position, zero when the span is zero
    function logic [7:0] ramp_level(logic [31:0] now, logic [15:0] span);
        logic [31:0] elapsed;
        logic [63:0] prod;
        elapsed = now - (event_ms - {16'd0, span});
        prod = {56'd0, cfg.max_level} * {32'd0, elapsed};
        if (span == 16'd0)
            return 8'd0;
        return 8'(prod[31:0] / {16'd0, span});
    endfunction

    // reversal mid-ramp: remaining time scaled by new_span / old_span
    function void rescale(logic [31:0] now, logic [15:0] new_span, logic [15:0] old_span);
        logic [31:0] remaining;
        logic [31:0] scaled;
        logic [63:0] prod;
        remaining = event_ms - now;
        prod = {48'd0, new_span} * {32'd0, remaining};
        scaled = (old_span == 16'd0) ? 32'd0 : prod[31:0] / {16'd0, old_span};
        event_ms = now + scaled;
        n_reversals++;
    endfunction

    function void tick(logic [31:0] now);
        logic [7:0]  v;
        int unsigned acc_sum;
        case (phase)
            PH_OFF: begin
                if (blink_on && now >= event_ms) begin
                    event_ms = now + {16'd0, cfg.rise_ms};
                    phase = PH_RISING;
                    n_blink_rises++;
                end
            end
            PH_RISING: begin
                if (now < event_ms) begin
                    v = ramp_level(now, cfg.rise_ms);
                    level = cfg.inverted ? 8'hFF - v : v;
                end else begin
                    level = cfg.inverted ? 8'hFF - cfg.max_level : cfg.max_level;
                    event_ms = now + {16'd0, cfg.on_ms};
                    phase = PH_ON;
                end
            end
            PH_ON: begin
                if (blink_on && now >= event_ms) begin
                    event_ms = now + {16'd0, cfg.fall_ms};
                    phase = PH_FALLING;
                end
            end
            default: begin
                if (now < event_ms) begin
                    v = ramp_level(now, cfg.fall_ms);
                    level = cfg.inverted ? v + 8'hFF - cfg.max_level : cfg.max_level - v;
                end else begin
                    level = cfg.inverted ? 8'hFF : 8'h00;
                    phase = PH_OFF;
                    event_ms = now + {16'd0, cfg.period_ms} - {16'd0, cfg.on_ms}
                             - {16'd0, cfg.rise_ms} - {16'd0, cfg.fall_ms};
                end
            end
        endcase
        acc_sum = duty_acc + cfg.inverted + (level >> (LEVEL_BITS - ACC_BITS));
        soft_hold = (acc_sum >> ACC_BITS) != 0;
        duty_acc = acc_sum[ACC_BITS-1:0];
    endfunction

    function void note_request(t_in_word w);
        t_out_word want;
        case (w.action)
            ACT_TICK: tick(w.now_ms);
            ACT_ON: begin
                if (phase == PH_OFF) begin
                    event_ms = w.now_ms + {16'd0, cfg.rise_ms};
                    phase = PH_RISING;
                end else if (phase == PH_FALLING) begin
                    rescale(w.now_ms, cfg.rise_ms, cfg.fall_ms);
                    phase = PH_RISING;
                end
                blink_on = 1'b0;
            end
            ACT_OFF: begin
                if (phase == PH_ON) begin
                    event_ms = w.now_ms + {16'd0, cfg.fall_ms};
                    phase = PH_FALLING;
                end else if (phase == PH_RISING) begin
                    rescale(w.now_ms, cfg.fall_ms, cfg.rise_ms);
                    phase = PH_FALLING;
                end
                blink_on = 1'b0;
            end
            default: begin
                if ({16'd0, cfg.period_ms} >= {16'd0, cfg.rise_ms} + {16'd0, cfg.on_ms}
                                              + {16'd0, cfg.fall_ms})
                    blink_on = 1'b1;
            end
        endcase
        want.level     = level;
        want.soft_bit  = soft_hold;
        want.phase_out = phase;
        want.blinking  = blink_on;
        pending_words.push_back(want);
    endfunction

    function void check_word(t_out_word got);
        t_out_word want;
        if (pending_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual %0h", $time, got);
            return;
        end
        want = pending_words.pop_front();
        n_checked++;
        compare_field("level", want.level, got.level);
        compare_field("soft_bit", want.soft_bit, got.soft_bit);
        compare_field("phase_out", want.phase_out, got.phase_out);
        compare_field("blinking", want.blinking, got.blinking);
    endfunction
endclass

module tb_led_fade_blink_controller;

    localparam int RESET_CYCLES    = 11;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int RANDOM_PHASES   = 10;
    localparam int WORDS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES   = 40;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_word                 i_in_word;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_word                o_out_word;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    dimmer_scoreboard sb = new();
    int               send_idle_pct = 24;
    int               recv_idle_pct = 83;
    bit               hold_req = 1'b0;
    int               hold_left = 0;
    int               idle_count = 0;
    int               n_settings = 0;
    logic [31:0]      clock_ms = '0;

    led_fade_blink_controller i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // output side: random stall, or a long hold-off on request
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_out_word);
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
            $display("led_fade_blink_controller verification failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic send_action(input logic [1:0] action, input logic [31:0] now);
        t_in_word w;
        w.action = action;
        w.now_ms = now;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    // write then read back one register
    task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        sb.compare_field("register readback", sb.reg_value(idx), readback);
    endtask

    task automatic load_settings(input t_cfg c);
        program_reg(REG_MAX_LEVEL, 32'(c.max_level));
        program_reg(REG_RISE_MS, 32'(c.rise_ms));
        program_reg(REG_FALL_MS, 32'(c.fall_ms));
        program_reg(REG_ON_MS, 32'(c.on_ms));
        program_reg(REG_PERIOD_MS, 32'(c.period_ms));
        program_reg(REG_INVERTED, 32'(c.inverted));
        n_settings++;
    endtask

    function automatic logic [15:0] rand_span();
        int unsigned r;
        r = $urandom_range(7);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(80, 1));
    endfunction

    function automatic t_cfg pick_settings(int idx);
        t_cfg        c;
        int unsigned spans;
        int unsigned r;
        if (idx == 0) begin
            c.max_level = 8'd0;
            c.rise_ms   = 16'hFFFF;
            c.fall_ms   = 16'hFFFF;
            c.on_ms     = 16'hFFFF;
            c.period_ms = 16'hFFFF;
            c.inverted  = 1'b0;
            return c;
        end
        r = $urandom_range(5);
        c.max_level = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
        if (idx == 1) begin
            c.max_level = 8'hFF;
            c.rise_ms   = 16'($urandom_range(40, 1));
            c.fall_ms   = 16'($urandom_range(40, 1));
            c.on_ms     = 16'($urandom_range(30, 1));
        end else begin
            c.rise_ms = rand_span();
            c.fall_ms = rand_span();
            c.on_ms   = rand_span();
        end
        spans = c.rise_ms + c.fall_ms + c.on_ms;
        if (idx > 1 && $urandom_range(4) == 0) begin
            c.period_ms = 16'($urandom_range(65535));
        end else begin
            spans = spans + $urandom_range(60);
            c.period_ms = (spans > 65535) ? 16'hFFFF : 16'(spans);
        end
        c.inverted = (idx == 1) ? 1'b1 : 1'($urandom_range(1));
        return c;
    endfunction

    task automatic send_random_item(input int step_max, input int switch_pct);
        int unsigned r;
        logic [31:0] t;
        r = $urandom_range(99);
        if (r >= 95) begin
            t = $urandom;
            if ($urandom_range(1) == 1)
                clock_ms = t;
            send_action(2'($urandom_range(3)), t);
        end else begin
            clock_ms = clock_ms + $urandom_range(step_max);
            if (r < switch_pct)
                send_action(ACT_ON, clock_ms);
            else if (r < 2 * switch_pct)
                send_action(ACT_OFF, clock_ms);
            else if (r < 2 * switch_pct + 8)
                send_action(ACT_BLINK, clock_ms);
            else
                send_action(ACT_TICK, clock_ms);
        end
    endtask

    task automatic run_directed();
        t_cfg c;
        // power-on settings: ramps, reversals, kept phases, one blink cycle, time wrap
        send_action(ACT_TICK, 32'd0);
        send_action(ACT_ON, 32'd10);
        send_action(ACT_TICK, 32'd10);
        send_action(ACT_TICK, 32'd135);
        send_action(ACT_OFF, 32'd185);
        send_action(ACT_TICK, 32'd200);
        send_action(ACT_ON, 32'd210);
        send_action(ACT_TICK, 32'd400);
        send_action(ACT_ON, 32'd410);
        send_action(ACT_OFF, 32'd420);
        send_action(ACT_OFF, 32'd430);
        send_action(ACT_TICK, 32'd700);
        send_action(ACT_BLINK, 32'd710);
        send_action(ACT_TICK, 32'd720);
        send_action(ACT_TICK, 32'd900);
        send_action(ACT_TICK, 32'd1200);
        send_action(ACT_TICK, 32'd1400);
        send_action(ACT_TICK, 32'd1500);
        send_action(ACT_TICK, 32'd1700);
        send_action(ACT_ON, 32'hFFFF_FFF0);
        send_action(ACT_TICK, 32'hFFFF_FFFF);
        wait_drained();
        // zero spans and period, inverted: zero divisors in both reversals
        c.max_level = 8'hFF;
        c.rise_ms   = 16'd0;
        c.fall_ms   = 16'd0;
        c.on_ms     = 16'd0;
        c.period_ms = 16'd0;
        c.inverted  = 1'b1;
        load_settings(c);
        send_action(ACT_OFF, 32'd5);
        send_action(ACT_ON, 32'd5);
        send_action(ACT_OFF, 32'd5);
        send_action(ACT_TICK, 32'd5);
        send_action(ACT_BLINK, 32'd6);
        send_action(ACT_TICK, 32'd6);
        send_action(ACT_TICK, 32'd6);
        send_action(ACT_TICK, 32'd6);
        wait_drained();
    endtask

    initial begin
        t_cfg c;
        int   step_max;
        int   switch_pct;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (RESET_CYCLES)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 4) begin
                send_idle_pct = 83;
                recv_idle_pct = 24;
            end
            if (p == 7) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            c = pick_settings(p);
            load_settings(c);
            step_max = (c.rise_ms + c.fall_ms + c.on_ms) / 12 + 2;
            switch_pct = $urandom_range(8, 2);
            clock_ms = $urandom;
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                if (i == 50 && (p == 2 || p == 8))
                    hold_req = 1'b1;
                send_random_item(step_max, switch_pct);
            end
            wait_drained();
        end
        repeat (SETTLE_CYCLES)
            @(posedge i_clk);
        $display("run checked %0d result words over %0d register settings", sb.n_checked,
                 n_settings);
        $display("with %0d ramp reversals and %0d blink rises under varied idling and hold-off",
                 sb.n_reversals, sb.n_blink_rises);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("led_fade_blink_controller verification clean");
        end else begin
            $display("led_fade_blink_controller verification failed");
        end
        $finish;
    end

endmodule
